@@ design/sep_pkg.sv @@
`timescale 1ns / 1ps

package sep_pkg;

    // Stream characters
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Input item kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_EOS  = 1'b1;

    // Result kinds
    localparam logic [1:0] OUT_DATA = 2'd0;
    localparam logic [1:0] OUT_NAME = 2'd1;
    localparam logic [1:0] OUT_END  = 2'd2;

    // Field kinds of a line
    localparam logic [1:0] KIND_OTHER   = 2'd0;
    localparam logic [1:0] KIND_EVENT   = 2'd1;
    localparam logic [1:0] KIND_DATA    = 2'd2;
    localparam logic [1:0] KIND_IDRETRY = 2'd3;

    // Line parse phase
    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_FIELD  = 5'b00010,
        PH_VSTART = 5'b00100,
        PH_VALUE  = 5'b01000,
        PH_SKIP   = 5'b10000
    } sep_phase_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic cr_step;
        logic main_step;
        logic end_step;
        logic disp;
        logic rd;
        logic name_emit;
        logic end_emit;
        logic flush;
    } sep_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic eos;
        logic lf;
        logic held;
        logic ph_start;
        logic pending;
        logic has_name;
        logic last_name;
        logic room;
        logic flush_ok;
    } sep_stat_t;

endpackage

@@ design/sep_ctrl.sv @@
`timescale 1ns / 1ps

module sep_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sep_pkg::sep_stat_t stat,
    output sep_pkg::sep_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DECODE = 10'b0000000010,
        S_CR     = 10'b0000000100,
        S_MAIN   = 10'b0000001000,
        S_ENDL   = 10'b0000010000,
        S_DISP   = 10'b0000100000,
        S_RD     = 10'b0001000000,
        S_NAME   = 10'b0010000000,
        S_ENDREC = 10'b0100000000,
        S_FLUSH  = 10'b1000000000
    } sep_state_t;

    sep_state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.eos)
                begin
                    state_next = (!stat.ph_start || stat.held) ? S_ENDL : S_DISP;
                end
                else if (stat.lf)
                begin
                    state_next = S_ENDL;
                end
                else
                begin
                    state_next = stat.held ? S_CR : S_MAIN;
                end
            end
            S_CR:
            begin
                if (stat.room)
                begin
                    cmd.cr_step = 1'b1;
                    state_next  = S_MAIN;
                end
            end
            S_MAIN:
            begin
                if (stat.room)
                begin
                    cmd.main_step = 1'b1;
                    state_next    = S_FLUSH;
                end
            end
            S_ENDL:
            begin
                if (stat.room)
                begin
                    cmd.end_step = 1'b1;
                    state_next   = (stat.ph_start || stat.eos) ? S_DISP : S_FLUSH;
                end
            end
            S_DISP:
            begin
                cmd.disp = 1'b1;
                if (!stat.pending)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    state_next = stat.has_name ? S_RD : S_ENDREC;
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_NAME;
            end
            S_NAME:
            begin
                if (stat.room)
                begin
                    cmd.name_emit = 1'b1;
                    state_next    = stat.last_name ? S_ENDREC : S_RD;
                end
            end
            S_ENDREC:
            begin
                if (stat.room)
                begin
                    cmd.end_emit = 1'b1;
                    state_next   = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (stat.flush_ok)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/sep_dpath.sv @@
`timescale 1ns / 1ps

module sep_dpath
#(
    parameter int NAME_MAX = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  sep_pkg::sep_cmd_t  cmd,
    output sep_pkg::sep_stat_t stat,
    input  logic               in_req,
    input  logic [7:0]         in_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_kind,
    output logic [7:0]         out_byte,
    output logic               out_trunc,
    output logic               out_last
);

    localparam int LEN_W = $clog2(NAME_MAX + 1);
    localparam int IDX_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

    // Character of a known field name at a position; zero past its end
    function automatic logic [7:0] fld_char(input logic [1:0] idx, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (idx)
            2'd0:
            begin
                case (pos)
                    3'd0: c = 8'h65;
                    3'd1: c = 8'h76;
                    3'd2: c = 8'h65;
                    3'd3: c = 8'h6E;
                    3'd4: c = 8'h74;
                    default: c = 8'h00;
                endcase
            end
            2'd1:
            begin
                case (pos)
                    3'd0: c = 8'h64;
                    3'd1: c = 8'h61;
                    3'd2: c = 8'h74;
                    3'd3: c = 8'h61;
                    default: c = 8'h00;
                endcase
            end
            2'd2:
            begin
                case (pos)
                    3'd0: c = 8'h69;
                    3'd1: c = 8'h64;
                    default: c = 8'h00;
                endcase
            end
            default:
            begin
                case (pos)
                    3'd0: c = 8'h72;
                    3'd1: c = 8'h65;
                    3'd2: c = 8'h74;
                    3'd3: c = 8'h72;
                    3'd4: c = 8'h79;
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic [2:0] fld_len(input logic [1:0] idx);
        logic [2:0] n;
        case (idx)
            2'd0:    n = 3'd5;
            2'd1:    n = 3'd4;
            2'd2:    n = 3'd2;
            default: n = 3'd5;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] fld_kind(input logic [1:0] idx);
        logic [1:0] k;
        case (idx)
            2'd0:    k = sep_pkg::KIND_EVENT;
            2'd1:    k = sep_pkg::KIND_DATA;
            default: k = sep_pkg::KIND_IDRETRY;
        endcase
        return k;
    endfunction

    // Latched item
    logic             req_reg;
    logic [7:0]       byte_reg;

    // Line parse state
    sep_pkg::sep_phase_t phase_reg, phase_next;
    logic [3:0]       mask_reg, mask_next;
    logic [2:0]       pos_reg, pos_next;
    logic             held_reg, held_next;
    logic [1:0]       kind_reg, kind_next;
    logic             pending_reg, pending_next;
    logic             seen_reg, seen_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;

    // Dispatch walk
    logic [LEN_W-1:0] walk_len_reg;
    logic [LEN_W-1:0] idx_reg;
    logic             trunc_reg;
    logic [7:0]       rd_data_reg;

    // Name store
    logic [7:0]       name_mem [NAME_MAX];
    logic             wr_en;

    // Result staging and output register
    logic             st_valid_reg;
    logic [1:0]       st_kind_reg;
    logic [7:0]       st_byte_reg;
    logic             st_trunc_reg;
    logic             out_valid_reg;
    logic [1:0]       out_kind_reg;
    logic [7:0]       out_byte_reg;
    logic             out_trunc_reg;
    logic             out_last_reg;

    logic             produce;
    logic [1:0]       p_kind;
    logic [7:0]       p_byte;
    logic             p_trunc;

    logic [7:0]       lb;
    logic [3:0]       m_cur;
    logic [2:0]       p_cur;
    logic [1:0]       sk;
    logic             do_settle;
    logic             do_value;
    logic             out_free;
    logic             load_out;

    assign lb       = cmd.cr_step ? sep_pkg::CH_CR : byte_reg;
    assign out_free = !out_valid_reg || out_ready;

    // Field kind from the live candidates at the current position
    always_comb
    begin
        sk = sep_pkg::KIND_OTHER;
        for (int i = 0; i < 4; i++)
        begin
            if (mask_reg[i] && pos_reg == fld_len(2'(i)))
            begin
                sk = fld_kind(2'(i));
            end
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        mask_next    = mask_reg;
        pos_next     = pos_reg;
        held_next    = held_reg;
        kind_next    = kind_reg;
        pending_next = pending_reg;
        seen_next    = seen_reg;
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        produce      = 1'b0;
        p_kind       = sep_pkg::OUT_DATA;
        p_byte       = 8'h00;
        p_trunc      = 1'b0;
        wr_en        = 1'b0;
        do_settle    = 1'b0;
        do_value     = 1'b0;
        m_cur        = (phase_reg == sep_pkg::PH_START) ? 4'hF : mask_reg;
        p_cur        = (phase_reg == sep_pkg::PH_START) ? 3'd0 : pos_reg;

        if (cmd.cr_step)
        begin
            held_next = 1'b0;
        end

        if (cmd.main_step && byte_reg == sep_pkg::CH_CR)
        begin
            held_next = 1'b1;
        end
        else if (cmd.cr_step || cmd.main_step)
        begin
            case (phase_reg)
                sep_pkg::PH_START, sep_pkg::PH_FIELD:
                begin
                    if (lb == sep_pkg::CH_COLON)
                    begin
                        if (phase_reg == sep_pkg::PH_START)
                        begin
                            phase_next = sep_pkg::PH_SKIP;
                        end
                        else
                        begin
                            do_settle  = 1'b1;
                            phase_next = (sk == sep_pkg::KIND_EVENT || sk == sep_pkg::KIND_DATA)
                                         ? sep_pkg::PH_VSTART : sep_pkg::PH_SKIP;
                        end
                    end
                    else
                    begin
                        phase_next = sep_pkg::PH_FIELD;
                        for (int i = 0; i < 4; i++)
                        begin
                            mask_next[i] = m_cur[i] && (p_cur < fld_len(2'(i)))
                                           && (fld_char(2'(i), p_cur) == lb);
                        end
                        pos_next = (p_cur == 3'd7) ? p_cur : p_cur + 3'd1;
                    end
                end
                sep_pkg::PH_VSTART:
                begin
                    phase_next = sep_pkg::PH_VALUE;
                    do_value   = (lb != sep_pkg::CH_SPACE);
                end
                sep_pkg::PH_VALUE:
                begin
                    do_value = 1'b1;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (cmd.end_step)
        begin
            do_settle = (phase_reg == sep_pkg::PH_FIELD);
        end

        // Value byte: data goes out, event name goes to the store
        if (do_value)
        begin
            if (kind_reg == sep_pkg::KIND_DATA)
            begin
                produce = 1'b1;
                p_byte  = lb;
            end
            else if (kind_reg == sep_pkg::KIND_EVENT)
            begin
                if (len_reg < LEN_W'(NAME_MAX))
                begin
                    wr_en    = 1'b1;
                    len_next = len_reg + LEN_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
        end

        // Field settles: restart name, separate data lines, mark a dispatch pending
        if (do_settle)
        begin
            kind_next = sk;
            case (sk)
                sep_pkg::KIND_EVENT:
                begin
                    len_next     = '0;
                    ovf_next     = 1'b0;
                    pending_next = 1'b1;
                end
                sep_pkg::KIND_DATA:
                begin
                    if (seen_reg)
                    begin
                        produce = 1'b1;
                        p_byte  = sep_pkg::CH_LF;
                    end
                    seen_next    = 1'b1;
                    pending_next = 1'b1;
                end
                sep_pkg::KIND_IDRETRY:
                begin
                    pending_next = 1'b1;
                end
                default:
                begin
                    pending_next = pending_reg;
                end
            endcase
        end

        if (cmd.end_step)
        begin
            held_next  = 1'b0;
            phase_next = sep_pkg::PH_START;
            kind_next  = sep_pkg::KIND_OTHER;
            mask_next  = 4'hF;
            pos_next   = 3'd0;
        end

        if (cmd.disp && pending_reg)
        begin
            len_next     = '0;
            ovf_next     = 1'b0;
            pending_next = 1'b0;
            seen_next    = 1'b0;
        end

        if (cmd.name_emit)
        begin
            produce = 1'b1;
            p_kind  = sep_pkg::OUT_NAME;
            p_byte  = rd_data_reg;
        end

        if (cmd.end_emit)
        begin
            produce = 1'b1;
            p_kind  = sep_pkg::OUT_END;
            p_trunc = trunc_reg;
        end
    end

    assign load_out = st_valid_reg && (produce || cmd.flush);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sep_pkg::PH_START;
            mask_reg      <= 4'hF;
            pos_reg       <= 3'd0;
            held_reg      <= 1'b0;
            kind_reg      <= sep_pkg::KIND_OTHER;
            pending_reg   <= 1'b0;
            seen_reg      <= 1'b0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            mask_reg    <= mask_next;
            pos_reg     <= pos_next;
            held_reg    <= held_next;
            kind_reg    <= kind_next;
            pending_reg <= pending_next;
            seen_reg    <= seen_next;
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            if (produce)
            begin
                st_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                st_valid_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg  <= in_req;
            byte_reg <= in_byte;
        end
        if (cmd.disp)
        begin
            walk_len_reg <= len_reg;
            trunc_reg    <= ovf_reg;
            idx_reg      <= '0;
        end
        else if (cmd.name_emit)
        begin
            idx_reg <= idx_reg + LEN_W'(1);
        end
        if (produce)
        begin
            st_kind_reg  <= p_kind;
            st_byte_reg  <= p_byte;
            st_trunc_reg <= p_trunc;
        end
        if (load_out)
        begin
            out_kind_reg  <= st_kind_reg;
            out_byte_reg  <= st_byte_reg;
            out_trunc_reg <= st_trunc_reg;
            out_last_reg  <= cmd.flush;
        end
    end

    // Name store: write on event value bytes, registered read during the walk
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            name_mem[len_reg[IDX_W-1:0]] <= lb;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= name_mem[idx_reg[IDX_W-1:0]];
        end
    end

    assign stat.eos       = (req_reg == sep_pkg::REQ_EOS);
    assign stat.lf        = (byte_reg == sep_pkg::CH_LF);
    assign stat.held      = held_reg;
    assign stat.ph_start  = (phase_reg == sep_pkg::PH_START);
    assign stat.pending   = pending_reg;
    assign stat.has_name  = (len_reg != '0);
    assign stat.last_name = (idx_reg == walk_len_reg - LEN_W'(1));
    assign stat.room      = !st_valid_reg || out_free;
    assign stat.flush_ok  = !st_valid_reg || out_free;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign out_trunc = out_trunc_reg;
    assign out_last  = out_last_reg;

endmodule

@@ design/sse_event_stream_parser.sv @@
`timescale 1ns / 1ps

// Server-sent-events parser. The slave channel takes one item per stream
// byte (tuser = 0, byte in tdata) or an end-of-stream item (tuser = 1),
// which closes an open line and dispatches a pending event. The master
// channel returns data bytes as they arrive, then on a blank line or end of
// stream the stored event name bytes followed by an end record; tlast marks
// the final result of each input item.
// Sequencing: one item at a time; a controller walks the steps each item
// needs. A plain byte passes decode, main and flush, with a CR step first
// when a held CR is replayed; a line end passes decode, line end, dispatch
// when it reaches it, and flush. A pending event adds a registered read of
// the name store and an emit per stored name byte, then the end record. An
// end of stream at line start with no held CR skips the line-end step. The
// last result sits in the output register while the next item is accepted.
// Reset clears the line parser, event state and output valid; the name
// store holds no reset value and is only read below the stored length.
// When the receiver stalls, hold: results wait in a staging register and
// the output register, and the controller stops until room frees up.
module sse_event_stream_parser
#(
    parameter int NAME_MAX = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tuser,   // [0] req_type
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [2:0] m_axis_tuser,   // [1:0] out_kind, [2] name_truncated
    output logic       m_axis_tlast
);

    sep_pkg::sep_cmd_t  cmd;
    sep_pkg::sep_stat_t stat;
    logic [1:0]         out_kind;
    logic               out_trunc;

    // Sequence each item through its parse steps
    sep_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Line parser, name store and result registers
    sep_dpath
    #(
        .NAME_MAX (NAME_MAX)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_req    (s_axis_tuser),
        .in_byte   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (out_kind),
        .out_byte  (m_axis_tdata),
        .out_trunc (out_trunc),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tuser = {out_trunc, out_kind};

endmodule

@@ verif/sse_event_stream_parser_test.sv @@
`timescale 1ns / 1ps

module sse_event_stream_parser_test;

    localparam int NAME_MAX     = 32;
    localparam int ITEM_TARGET  = 280;
    localparam int TAIL_ITEMS   = 50;
    localparam int SETTLE_WAIT  = 100;
    localparam int DRAIN_LIMIT  = 20000;

    // One result record as it leaves the master channel
    typedef struct {
        logic [1:0] kind;
        logic [7:0] value;
        logic       trunc;
        logic       last;
    } sse_record_t;

    // Tracks parser state, computes the records each item must produce, and
    // checks what the block returns against them in order.
    class sse_record_board;
        sep_pkg::sep_phase_t phase;
        logic [3:0]  match_mask;
        logic [2:0]  field_pos;
        logic        held_cr;
        logic [1:0]  line_kind;
        logic        pending;
        logic        data_seen;
        logic [7:0]  name_bytes [NAME_MAX];
        int          name_len;
        logic        name_ovf;
        sse_record_t awaited [$];
        int          errors;
        string       fld_name [4] = '{"event", "data", "id", "retry"};
        logic [1:0]  fld_kind [4] = '{sep_pkg::KIND_EVENT, sep_pkg::KIND_DATA,
                                      sep_pkg::KIND_IDRETRY, sep_pkg::KIND_IDRETRY};

        function new();
            phase      = sep_pkg::PH_START;
            match_mask = 4'hF;
            field_pos  = 3'd0;
            held_cr    = 1'b0;
            line_kind  = sep_pkg::KIND_OTHER;
            pending    = 1'b0;
            data_seen  = 1'b0;
            name_len   = 0;
            name_ovf   = 1'b0;
            errors     = 0;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("%0t mismatch: %s", $time, msg);
        endtask

        function void emit(logic [1:0] kind, logic [7:0] value, logic trunc);
            sse_record_t rec;
            rec.kind  = kind;
            rec.value = value;
            rec.trunc = trunc;
            rec.last  = 1'b0;
            awaited.push_back(rec);
        endfunction

        // Field kind is fixed at the colon, or at the end of a colon-less line
        function void settle_field();
            line_kind = sep_pkg::KIND_OTHER;
            for (int i = 0; i < 4; i++)
                if (match_mask[i] && field_pos == fld_name[i].len())
                    line_kind = fld_kind[i];
            if (line_kind == sep_pkg::KIND_EVENT)
            begin
                name_len = 0;
                name_ovf = 1'b0;
                pending  = 1'b1;
            end
            else if (line_kind == sep_pkg::KIND_DATA)
            begin
                if (data_seen)
                    emit(sep_pkg::OUT_DATA, sep_pkg::CH_LF, 1'b0);
                data_seen = 1'b1;
                pending   = 1'b1;
            end
            else if (line_kind == sep_pkg::KIND_IDRETRY)
            begin
                pending = 1'b1;
            end
        endfunction

        function void value_byte(logic [7:0] b);
            if (line_kind == sep_pkg::KIND_DATA)
            begin
                emit(sep_pkg::OUT_DATA, b, 1'b0);
            end
            else if (line_kind == sep_pkg::KIND_EVENT)
            begin
                if (name_len < NAME_MAX)
                begin
                    name_bytes[name_len] = b;
                    name_len++;
                end
                else
                begin
                    name_ovf = 1'b1;
                end
            end
        endfunction

        function void line_byte(logic [7:0] b);
            if (phase == sep_pkg::PH_START)
            begin
                if (b == sep_pkg::CH_COLON)
                begin
                    phase = sep_pkg::PH_SKIP;
                    return;
                end
                phase      = sep_pkg::PH_FIELD;
                match_mask = 4'hF;
                field_pos  = 3'd0;
            end
            case (phase)
                sep_pkg::PH_FIELD:
                begin
                    if (b == sep_pkg::CH_COLON)
                    begin
                        settle_field();
                        phase = (line_kind == sep_pkg::KIND_EVENT ||
                                 line_kind == sep_pkg::KIND_DATA)
                                ? sep_pkg::PH_VSTART : sep_pkg::PH_SKIP;
                        return;
                    end
                    // drop every candidate whose text differs at this position
                    for (int i = 0; i < 4; i++)
                        if (!(field_pos < fld_name[i].len() && fld_name[i][field_pos] == b))
                            match_mask[i] = 1'b0;
                    if (field_pos < 3'd7)
                        field_pos++;
                end
                sep_pkg::PH_VSTART:
                begin
                    phase = sep_pkg::PH_VALUE;
                    if (b != sep_pkg::CH_SPACE)
                        value_byte(b);
                end
                sep_pkg::PH_VALUE:
                    value_byte(b);
                default:
                    ;
            endcase
        endfunction

        function void dispatch();
            if (!pending)
                return;
            for (int i = 0; i < name_len; i++)
                emit(sep_pkg::OUT_NAME, name_bytes[i], 1'b0);
            emit(sep_pkg::OUT_END, 8'h00, name_ovf);
            name_len  = 0;
            name_ovf  = 1'b0;
            pending   = 1'b0;
            data_seen = 1'b0;
        endfunction

        function void end_line();
            held_cr = 1'b0;
            if (phase == sep_pkg::PH_START)
                dispatch();
            else if (phase == sep_pkg::PH_FIELD)
                settle_field();
            phase      = sep_pkg::PH_START;
            line_kind  = sep_pkg::KIND_OTHER;
            match_mask = 4'hF;
            field_pos  = 3'd0;
        endfunction

        function void note_stream_item(logic req, logic [7:0] b);
            int prior_size;
            prior_size = awaited.size();
            if (req == sep_pkg::REQ_EOS)
            begin
                if (phase != sep_pkg::PH_START || held_cr)
                    end_line();
                dispatch();
            end
            else if (b == sep_pkg::CH_LF)
            begin
                end_line();
            end
            else
            begin
                // a held CR that is not followed by LF becomes line content
                if (held_cr)
                begin
                    held_cr = 1'b0;
                    line_byte(sep_pkg::CH_CR);
                end
                if (b == sep_pkg::CH_CR)
                    held_cr = 1'b1;
                else
                    line_byte(b);
            end
            if (awaited.size() > prior_size)
                awaited[$].last = 1'b1;
        endfunction

        task check_record(logic [1:0] kind, logic [7:0] value, logic trunc, logic last);
            sse_record_t want;
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf(
                    "unexpected result kind %0d byte %02h trunc %0b last %0b",
                    kind, value, trunc, last));
                return;
            end
            want = awaited.pop_front();
            if (want.kind !== kind || want.value !== value || want.trunc !== trunc ||
                want.last !== last)
                report_mismatch($sformatf(
                    "got kind %0d byte %02h trunc %0b last %0b, want %0d %02h %0b %0b",
                    kind, value, trunc, last,
                    want.kind, want.value, want.trunc, want.last));
        endtask

        task check_leftover();
            if (awaited.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", awaited.size()));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tuser;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic       m_axis_tlast;

    sse_record_board board;
    int              sent_count;
    logic            quiet_tail;
    int              stall_left;
    string           odd_fields [10] = '{"dat", "datas", "even", "eventx", "i", "idd",
                                         "retr", "retryy", "DATA", "dataevent"};
    string           known_fields [4] = '{"event", "data", "id", "retry"};

    sse_event_stream_parser i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    // Receiver: stall in random bursts, none in the tail of the run
    initial
    begin
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
            begin
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 19);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_record(m_axis_tuser[1:0], m_axis_tdata, m_axis_tuser[2], m_axis_tlast);
    end

    // Hold the item until accepted, then maybe leave a gap
    task automatic push_item(input logic req, input logic [7:0] b);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        board.note_stream_item(req, b);
        sent_count++;
        if (sent_count >= ITEM_TARGET - TAIL_ITEMS)
            quiet_tail = 1'b1;
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_item(sep_pkg::REQ_BYTE, s[i]);
    endtask

    // Random value bytes; LF is replaced by 8'h8A so the line stays whole
    task automatic send_content(input int n);
        logic [7:0] b;
        repeat (n)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == sep_pkg::CH_LF)
                b = 8'h8A;
            push_item(sep_pkg::REQ_BYTE, b);
        end
    endtask

    // LF, CR LF, a lone CR, or nothing at all
    task automatic close_line();
        int pick;
        pick = $urandom_range(0, 11);
        if (pick == 0)
            return;
        if (pick <= 4)
            push_item(sep_pkg::REQ_BYTE, sep_pkg::CH_CR);
        if (pick != 1)
            push_item(sep_pkg::REQ_BYTE, sep_pkg::CH_LF);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (board.awaited.size() != 0);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    initial
    begin
        int  pick;
        int  guard;
        bit  paused;
        board         = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = sep_pkg::REQ_BYTE;
        sent_count    = 0;
        quiet_tail    = 1'b0;
        paused        = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: comment, data with byte extremes and CR as content,
        // colon-less data line, event name, blank CR LF line, id then end of stream
        send_text(":");
        push_item(sep_pkg::REQ_BYTE, sep_pkg::CH_LF);
        send_text("data:");
        push_item(sep_pkg::REQ_BYTE, 8'h00);
        push_item(sep_pkg::REQ_BYTE, sep_pkg::CH_CR);
        push_item(sep_pkg::REQ_BYTE, 8'hFF);
        push_item(sep_pkg::REQ_BYTE, sep_pkg::CH_CR);
        push_item(sep_pkg::REQ_BYTE, sep_pkg::CH_LF);
        send_text("data");
        push_item(sep_pkg::REQ_BYTE, sep_pkg::CH_LF);
        send_text("event:e");
        push_item(sep_pkg::REQ_BYTE, sep_pkg::CH_LF);
        push_item(sep_pkg::REQ_BYTE, sep_pkg::CH_CR);
        push_item(sep_pkg::REQ_BYTE, sep_pkg::CH_LF);
        send_text("id");
        push_item(sep_pkg::REQ_EOS, 8'hFF);

        // Name that overflows the store, then a blank line dispatches it
        send_text("event: ");
        send_content(NAME_MAX + 2);
        push_item(sep_pkg::REQ_BYTE, sep_pkg::CH_LF);
        push_item(sep_pkg::REQ_BYTE, sep_pkg::CH_LF);

        while (sent_count < ITEM_TARGET)
        begin
            if (!paused && sent_count >= ITEM_TARGET / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                send_text("data:");
                if ($urandom_range(0, 1))
                    push_item(sep_pkg::REQ_BYTE, sep_pkg::CH_SPACE);
                send_content($urandom_range(0, 6));
                close_line();
            end
            else if (pick < 44)
            begin
                send_text("event:");
                if ($urandom_range(0, 1))
                    push_item(sep_pkg::REQ_BYTE, sep_pkg::CH_SPACE);
                send_content($urandom_range(0, 9) == 0 ? $urandom_range(30, 36)
                                                       : $urandom_range(0, 5));
                close_line();
            end
            else if (pick < 52)
            begin
                if ($urandom_range(0, 1))
                    send_text("id:");
                else
                    send_text("retry: ");
                send_content($urandom_range(0, 4));
                close_line();
            end
            else if (pick < 58)
            begin
                push_item(sep_pkg::REQ_BYTE, sep_pkg::CH_COLON);
                send_content($urandom_range(0, 4));
                close_line();
            end
            else if (pick < 64)
            begin
                send_text(odd_fields[$urandom_range(0, 9)]);
                if ($urandom_range(0, 1))
                    push_item(sep_pkg::REQ_BYTE, sep_pkg::CH_COLON);
                send_content($urandom_range(0, 3));
                close_line();
            end
            else if (pick < 70)
            begin
                send_text(known_fields[$urandom_range(0, 3)]);
                close_line();
            end
            else if (pick < 85)
            begin
                close_line();
            end
            else if (pick < 90)
            begin
                push_item(sep_pkg::REQ_EOS, 8'($urandom_range(0, 255)));
            end
            else
            begin
                // noise: any byte, LF, CR and colon included
                repeat ($urandom_range(1, 4))
                    push_item(sep_pkg::REQ_BYTE, 8'($urandom_range(0, 255)));
            end
        end

        // Flush whatever is left so the final event is dispatched
        push_item(sep_pkg::REQ_EOS, 8'h00);
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (board.awaited.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_WAIT) @(posedge clk);
        board.check_leftover();
        if (board.errors == 0)
            $display("sse_event_stream_parser_test: done, clean");
        else
            $display("sse_event_stream_parser_test: done, errors");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("sse_event_stream_parser_test: done, errors");
        $finish;
    end

endmodule
